>>> rtl/tft_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the transition frequency table.
package tft_pkg;

	localparam int TOKEN_W = 8;
	localparam int SLOT_W  = 4;
	localparam int CNT_W   = 16;
	localparam int TOTAL_W = 32;
	localparam int LEN_W   = 5;

	typedef enum logic [1:0] {
		RES_HIT  = 2'd0,
		RES_NEW  = 2'd1,
		RES_FULL = 2'd2
	} result_t;

	typedef struct packed {
		logic [TOKEN_W-1:0] dst;
		logic [TOKEN_W-1:0] src;
	} in_data_t;

	typedef struct packed {
		logic [6:0]         pad;
		logic [LEN_W-1:0]   list_len;
		logic [TOTAL_W-1:0] total;
		logic [CNT_W-1:0]   entry_count;
		logic [SLOT_W-1:0]  slot;
	} out_data_t;

	typedef struct packed {
		logic clr;
		logic load;
		logic rd;
		logic upd;
	} tft_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic out_busy;
	} tft_stat_t;

endpackage

>>> rtl/transition_frequency_table.sv
`timescale 1ns / 1ps
// Top level: per-token follower count table with transpose reordering.
// Flow: the accepted request is registered, then the row and list metadata are read into
// registers, then the updated row is written back and the result is registered. One request
// is in flight at a time; the update waits while the result register still holds an untaken result.
// Reset: list lengths and totals are cleared by a pass over all NUM_TOKENS entries after
// reset release; no request is accepted during it; reorder_enable resets to 1.
module transition_frequency_table #(
	parameter int NUM_TOKENS    = 256,
	parameter int MAX_FOLLOWERS = 16,
	parameter int COUNT_BITS    = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_data,  // reorder_enable
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // src_token[7:0], dst_token[15:8]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // slot[3:0], entry_count[19:4], total[51:20], list_len[56:52]
	output logic [1:0]  m_tuser    // status[1:0]
);
	import tft_pkg::*;

	tft_cmd_t  cmd;
	tft_stat_t stat;

	assign cfg_ready = 1'b1;

	tft_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	tft_dpath #(
		.NUM_TOKENS    (NUM_TOKENS),
		.MAX_FOLLOWERS (MAX_FOLLOWERS),
		.COUNT_BITS    (COUNT_BITS)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

endmodule

>>> rtl/tft_ctrl.sv
`timescale 1ns / 1ps
// Sequencer for clear pass, read and update of one request.
module tft_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  tft_pkg::tft_stat_t stat,
	output tft_pkg::tft_cmd_t  cmd
);
	import tft_pkg::*;

	typedef enum logic [3:0] {
		ST_CLEAR  = 4'b0001,
		ST_IDLE   = 4'b0010,
		ST_READ   = 4'b0100,
		ST_UPDATE = 4'b1000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clr = 1'b1;
				if (stat.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = ST_READ;
				end
			end
			ST_READ: begin
				cmd.rd  = 1'b1;
				state_d = ST_UPDATE;
			end
			ST_UPDATE: begin
				if (!stat.out_busy) begin
					cmd.upd = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

endmodule

>>> rtl/tft_dpath.sv
`timescale 1ns / 1ps
// Follower row store, list metadata store, row update and result register.
module tft_dpath #(
	parameter int NUM_TOKENS    = 256,
	parameter int MAX_FOLLOWERS = 16,
	parameter int COUNT_BITS    = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  tft_pkg::tft_cmd_t         cmd,
	output tft_pkg::tft_stat_t        stat,
	input  logic                      cfg_valid,
	input  logic                      cfg_data,
	input  logic [15:0]               s_tdata,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [63:0]               m_tdata,
	output logic [1:0]                m_tuser
);
	import tft_pkg::*;

	localparam int TW = (NUM_TOKENS > 1) ? $clog2(NUM_TOKENS) : 1;
	localparam int SW = $clog2(MAX_FOLLOWERS);
	localparam int LW = $clog2(MAX_FOLLOWERS + 1);

	typedef struct packed {
		logic [TOKEN_W-1:0]    id;
		logic [COUNT_BITS-1:0] cnt;
	} entry_t;

	typedef entry_t [MAX_FOLLOWERS-1:0] row_t;

	typedef struct packed {
		logic [LW-1:0]      len;
		logic [TOTAL_W-1:0] total;
	} meta_t;

	function automatic logic [TW-1:0] fold_src(input logic [TOKEN_W-1:0] s);
		logic [TOKEN_W-1:0] r;
		logic [63:0]        lim;
		r = s;
		for (int k = TOKEN_W - 1; k >= 0; k--) begin
			lim = 64'(NUM_TOKENS) << k;
			if (64'(r) >= lim) begin
				r = r - TOKEN_W'(lim);
			end
		end
		return TW'(r);
	endfunction

	row_t  row_mem  [NUM_TOKENS];
	meta_t meta_mem [NUM_TOKENS];

	in_data_t           in_req;
	logic [TW-1:0]      idx_s1;
	logic [TOKEN_W-1:0] dst_s1;
	row_t               row_s2;
	meta_t              meta_s2;
	logic [TW-1:0]      clr_addr_q;
	logic               reorder_q;
	logic               out_valid_q;
	out_data_t          out_data_q;
	result_t            out_res_q;

	logic                  hit;
	logic [SW-1:0]         hit_idx;
	logic [SW-1:0]         left_idx;
	logic [SW-1:0]         app_idx;
	logic [COUNT_BITS-1:0] cur_cnt;
	logic [COUNT_BITS-1:0] new_cnt;
	entry_t                left_ent;
	logic                  full;
	logic                  swap;
	row_t                  new_row;
	meta_t                 new_meta;
	logic [SW-1:0]         res_slot;
	logic [COUNT_BITS-1:0] res_cnt;
	result_t               res_kind;
	logic                  wr_en;

	assign in_req = in_data_t'(s_tdata);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reorder_q <= 1'b1;
		end else if (cfg_valid) begin
			reorder_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
		end else if (cmd.clr && !stat.clr_last) begin
			clr_addr_q <= clr_addr_q + 1'b1;
		end
	end

	assign stat.clr_last = (clr_addr_q == TW'(NUM_TOKENS - 1));
	assign stat.out_busy = out_valid_q && !m_tready;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			idx_s1 <= fold_src(in_req.src);
			dst_s1 <= in_req.dst;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			row_s2  <= row_mem[idx_s1];
			meta_s2 <= meta_mem[idx_s1];
		end
	end

	always_comb begin
		hit     = 1'b0;
		hit_idx = '0;
		for (int i = MAX_FOLLOWERS - 1; i >= 0; i--) begin
			if ((LW'(i) < meta_s2.len) && (row_s2[i].id == dst_s1)) begin
				hit     = 1'b1;
				hit_idx = SW'(i);
			end
		end
	end

	always_comb begin
		left_idx = hit_idx - 1'b1;
		app_idx  = SW'(meta_s2.len);
		cur_cnt  = row_s2[hit_idx].cnt;
		left_ent = row_s2[left_idx];
		new_cnt  = (cur_cnt == '1) ? cur_cnt : cur_cnt + 1'b1;
		full     = (meta_s2.len == LW'(MAX_FOLLOWERS));
		swap     = hit && reorder_q && (hit_idx != '0) && (new_cnt > left_ent.cnt);

		new_row        = row_s2;
		new_meta       = meta_s2;
		res_slot       = '0;
		res_cnt        = '0;
		res_kind       = RES_FULL;
		if (hit) begin
			new_meta.total = (meta_s2.total == '1) ? meta_s2.total : meta_s2.total + 1'b1;
			res_cnt        = new_cnt;
			res_kind       = RES_HIT;
			if (swap) begin
				new_row[left_idx].id  = dst_s1;
				new_row[left_idx].cnt = new_cnt;
				new_row[hit_idx]      = left_ent;
				res_slot              = left_idx;
			end else begin
				new_row[hit_idx].cnt = new_cnt;
				res_slot             = hit_idx;
			end
		end else if (!full) begin
			new_row[app_idx].id  = dst_s1;
			new_row[app_idx].cnt = COUNT_BITS'(1);
			new_meta.len         = meta_s2.len + 1'b1;
			new_meta.total = (meta_s2.total == '1) ? meta_s2.total : meta_s2.total + 1'b1;
			res_slot             = app_idx;
			res_cnt              = COUNT_BITS'(1);
			res_kind             = RES_NEW;
		end
		wr_en = cmd.upd && (hit || !full);
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			row_mem[idx_s1] <= new_row;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.clr) begin
			meta_mem[clr_addr_q] <= '0;
		end else if (wr_en) begin
			meta_mem[idx_s1] <= new_meta;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.upd) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.upd) begin
			out_data_q.pad         <= '0;
			out_data_q.list_len    <= LEN_W'(new_meta.len);
			out_data_q.total       <= new_meta.total;
			out_data_q.entry_count <= CNT_W'(res_cnt);
			out_data_q.slot        <= SLOT_W'(res_slot);
			out_res_q              <= res_kind;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = 64'(out_data_q);
	assign m_tuser  = out_res_q;

endmodule

>>> rtl/tft_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the transition frequency table, bound to the top level.
module tft_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [63:0] m_tdata,
	input logic [1:0]  m_tuser
);
	import tft_pkg::*;

	out_data_t d;

	assign d = out_data_t'(m_tdata);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	a_full_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == RES_FULL) |-> (d.slot == '0) && (d.entry_count == '0))
		else $error("dropped request reports a slot or count");

	a_new_one: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == RES_NEW) |-> (d.entry_count == CNT_W'(1)) && (d.list_len != '0))
		else $error("new entry without count of one");

	a_total_live: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != RES_FULL) |-> (d.total != '0))
		else $error("counted request with zero total");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request accepted while previous one in flight");

endmodule

bind transition_frequency_table tft_checker u_tft_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

>>> tb/follower_table_checker.sv
`timescale 1ns / 1ps
// Checker for the transition frequency table: predicts each follower update and compares results.
module follower_table_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic        cfg_data,  // reorder_enable
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [15:0] s_tdata,   // src_token[7:0], dst_token[15:8]
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [63:0] m_tdata,   // slot[3:0], entry_count[19:4], total[51:20], list_len[56:52]
	input  logic [1:0]  m_tuser,   // status[1:0]
	output int          outstanding,
	output int          fail_count
);
	import tft_pkg::*;

	localparam int NUM_TOKENS    = 256;
	localparam int MAX_FOLLOWERS = 16;
	localparam int MAX_REPORTS   = 10;
	localparam logic [CNT_W-1:0]   COUNT_MAX = '1;
	localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

	typedef struct {
		logic [TOKEN_W-1:0] src;
		logic [TOKEN_W-1:0] dst;
		logic [SLOT_W-1:0]  slot;
		logic [CNT_W-1:0]   entry_count;
		logic [TOTAL_W-1:0] total;
		logic [LEN_W-1:0]   list_len;
		result_t            status;
	} tally_t;

	logic [TOKEN_W-1:0] follower_ids    [NUM_TOKENS][MAX_FOLLOWERS];
	logic [CNT_W-1:0]   follower_counts [NUM_TOKENS][MAX_FOLLOWERS];
	int                 list_lengths    [NUM_TOKENS];
	logic [TOTAL_W-1:0] totals          [NUM_TOKENS];
	logic               reorder_on;
	tally_t             expected_tallies [$];

	function automatic tally_t count_transition(input logic [TOKEN_W-1:0] src_tok,
	                                            input logic [TOKEN_W-1:0] dst_tok);
		tally_t t;
		int n;
		int pos;
		logic [CNT_W-1:0] c;
		logic [CNT_W-1:0] left_cnt;
		logic [TOKEN_W-1:0] left_id;
		t.src = src_tok;
		t.dst = dst_tok;
		t.slot = '0;
		t.entry_count = '0;
		t.status = RES_FULL;
		n = list_lengths[src_tok];
		pos = -1;
		for (int i = 0; i < n; i++)
			if (pos < 0 && follower_ids[src_tok][i] == dst_tok)
				pos = i;
		if (pos >= 0) begin
			c = follower_counts[src_tok][pos];
			if (c != COUNT_MAX)
				c = c + 1'b1;
			follower_counts[src_tok][pos] = c;
			t.slot = SLOT_W'(pos);
			// transpose: move one place left on a strictly greater count
			if (reorder_on && pos > 0 && c > follower_counts[src_tok][pos-1]) begin
				left_cnt = follower_counts[src_tok][pos-1];
				left_id = follower_ids[src_tok][pos-1];
				follower_counts[src_tok][pos-1] = c;
				follower_ids[src_tok][pos-1] = dst_tok;
				follower_counts[src_tok][pos] = left_cnt;
				follower_ids[src_tok][pos] = left_id;
				t.slot = SLOT_W'(pos - 1);
			end
			if (totals[src_tok] != TOTAL_MAX)
				totals[src_tok] = totals[src_tok] + 1'b1;
			t.entry_count = c;
			t.status = RES_HIT;
		end else if (n < MAX_FOLLOWERS) begin
			follower_ids[src_tok][n] = dst_tok;
			follower_counts[src_tok][n] = CNT_W'(1);
			list_lengths[src_tok] = n + 1;
			if (totals[src_tok] != TOTAL_MAX)
				totals[src_tok] = totals[src_tok] + 1'b1;
			t.slot = SLOT_W'(n);
			t.entry_count = CNT_W'(1);
			t.status = RES_NEW;
		end
		t.total = totals[src_tok];
		t.list_len = LEN_W'(list_lengths[src_tok]);
		return t;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		tally_t want;
		out_data_t got;
		in_data_t req;
		if (!arst_n) begin
			foreach (follower_ids[i, j]) begin
				follower_ids[i][j] = '0;
				follower_counts[i][j] = '0;
			end
			foreach (list_lengths[i]) begin
				list_lengths[i] = 0;
				totals[i] = '0;
			end
			reorder_on = 1'b1;
			expected_tallies.delete();
			outstanding = 0;
			fail_count = 0;
		end else begin
			if (cfg_valid && cfg_ready)
				reorder_on = cfg_data;
			if (s_tvalid && s_tready) begin
				req = in_data_t'(s_tdata);
				expected_tallies.push_back(count_transition(req.src, req.dst));
			end
			if (m_tvalid && m_tready) begin
				got = out_data_t'(m_tdata);
				if (expected_tallies.size() == 0) begin
					if (fail_count < MAX_REPORTS)
						$display("unexpected result: slot %0d count %0d total %0d len %0d status %0d",
						         got.slot, got.entry_count, got.total, got.list_len, m_tuser);
					fail_count++;
				end else begin
					want = expected_tallies.pop_front();
					if (got.slot !== want.slot || got.entry_count !== want.entry_count ||
					    got.total !== want.total || got.list_len !== want.list_len ||
					    m_tuser !== want.status) begin
						if (fail_count < MAX_REPORTS) begin
							$display("mismatch for src %0d dst %0d", want.src, want.dst);
							$display("  expected slot %0d count %0d total %0d len %0d status %0d",
							         want.slot, want.entry_count, want.total, want.list_len,
							         want.status);
							$display("  actual   slot %0d count %0d total %0d len %0d status %0d",
							         got.slot, got.entry_count, got.total, got.list_len, m_tuser);
						end
						fail_count++;
					end
				end
			end
			outstanding = expected_tallies.size();
		end
	end

endmodule

>>> tb/tb_transition_frequency_table.sv
`timescale 1ns / 1ps
// Testbench top for the transition frequency table: clock, reset, request stimulus and verdict.
module tb_transition_frequency_table;
	import tft_pkg::*;

	localparam int CYCLE_LIMIT   = 2_000_000;
	localparam int HOLD_CYCLES   = 300;
	localparam int PHASE_ITEMS   = 263;
	localparam int MAX_FOLLOWERS = 16;
	localparam logic [TOKEN_W-1:0] FULL_SRC = 8'hA5;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic        cfg_data;  // reorder_enable
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;   // src_token[7:0], dst_token[15:8]
	logic        m_tvalid;
	logic        m_tready;
	logic [63:0] m_tdata;   // slot[3:0], entry_count[19:4], total[51:20], list_len[56:52]
	logic [1:0]  m_tuser;   // status[1:0]

	int outstanding;
	int fail_count;
	int cycles = 0;
	int hold_reqs = 0;
	logic [TOKEN_W-1:0] hot_srcs [4];
	logic [TOKEN_W-1:0] dst_base;

	transition_frequency_table dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	follower_table_checker table_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.outstanding (outstanding),
		.fail_count  (fail_count)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// receiver: alternate ready runs and stalls, hold off long on request
	initial begin
		int run;
		int hold_left;
		int holds_seen;
		logic level;
		m_tready = 1'b0;
		run = 0;
		hold_left = 0;
		holds_seen = 0;
		level = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_reqs != holds_seen) begin
				holds_seen = hold_reqs;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				level = 1'b0;
			end else begin
				if (run == 0) begin
					level = ~level;
					if (level)
						run = ($urandom_range(0, 4) == 0) ? 60 : $urandom_range(1, 20);
					else
						run = $urandom_range(1, 6);
				end
				run--;
			end
			m_tready <= level;
		end
	end

	task automatic offer(input logic [TOKEN_W-1:0] from_tok, input logic [TOKEN_W-1:0] to_tok);
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata <= in_data_t'{dst: to_tok, src: from_tok};
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic wait_drained;
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
	endtask

	task automatic set_reorder(input logic enable);
		wait_drained();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= enable;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic random_phase(input int n_items, input bit squeeze);
		int burst;
		int gap;
		int rush;
		int pick;
		burst = 0;
		rush = 0;
		if (squeeze) begin
			hold_reqs++;
			rush = 24;
		end
		for (int k = 0; k < n_items; k++) begin
			if (rush > 0) begin
				rush--;
			end else begin
				if (burst == 0) begin
					gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
					repeat (gap) begin
						@(negedge clk);
						s_tvalid <= 1'b0;
					end
					burst = $urandom_range(1, 16);
				end
				burst--;
			end
			if ($urandom_range(0, 9) < 7) begin
				pick = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 23) : $urandom_range(0, 5);
				offer(hot_srcs[$urandom_range(0, 3)], 8'(dst_base + pick));
			end else begin
				offer(8'($urandom), 8'($urandom));
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		foreach (hot_srcs[i])
			hot_srcs[i] = 8'($urandom);
		dst_base = 8'($urandom);
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		set_reorder(1'b1);

		// field extremes, append, swap and no swap on equal counts
		offer(8'h00, 8'h00);
		offer(8'hFF, 8'hFF);
		offer(8'hFF, 8'h00);
		offer(8'hFF, 8'h00);
		offer(8'hFF, 8'hFF);
		offer(8'h00, 8'h00);
		// fill one list, drop a miss on it, then swap its last entry
		for (int i = 0; i < MAX_FOLLOWERS; i++)
			offer(FULL_SRC, 8'(i * 17));
		offer(FULL_SRC, 8'h01);
		offer(FULL_SRC, 8'hFF);

		set_reorder(1'b0);
		random_phase(PHASE_ITEMS, 1'b1);
		set_reorder(1'b1);
		random_phase(PHASE_ITEMS, 1'b0);
		set_reorder(1'b0);
		random_phase(PHASE_ITEMS, 1'b0);
		set_reorder(1'b1);
		random_phase(PHASE_ITEMS, 1'b1);

		wait_drained();
		repeat (8) @(posedge clk);
		if (fail_count == 0 && outstanding == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
